FILE: sv/fvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_pkg
// Shared types and constants for the fan-triangulating vertex dedup core.
// ----------------------------------------------------------------------------
package fvd_pkg;

	localparam int unsigned KEY_W   = 24;
	localparam int unsigned MESH_W  = 16;
	localparam int unsigned VTOT_W  = 17;
	localparam int unsigned ITOT_W  = 24;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = 2;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [ITOT_W-1:0] ITOT_MAX = {ITOT_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one lookup request (or a short-face error) from front to back
	typedef struct packed {
		logic              short_face;
		logic              last;
		logic [KEY_W-1:0]  pos;
		logic [KEY_W-1:0]  tex;
		logic [KEY_W-1:0]  norm;
	} job_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_HASH,
		B_MOD,
		B_FILL_RD,
		B_FILL,
		B_WAY_RD,
		B_WAY_CMP,
		B_DECIDE,
		B_OUT
	} back_state_t;

endpackage

FILE: sv/fvd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fvd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/fvd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_queue
// Small request FIFO between the corner front end and the lookup engine.
// ----------------------------------------------------------------------------
module fvd_queue
	import fvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic nonempty
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_job  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

endmodule

FILE: sv/fvd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_front
// Corner intake: holds fan corners, issues three lookup requests per
// triangle or one error request for a short face.
// ----------------------------------------------------------------------------
module fvd_front
	import fvd_pkg::*;
#(
	parameter int unsigned MAX_CORNERS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [KEY_W-1:0] pos_index,
	input  logic [KEY_W-1:0] tex_index,
	input  logic [KEY_W-1:0] norm_index,
	input  logic             last_corner,
	output logic             push,
	output job_t             push_job,
	input  logic             full
);

	localparam int unsigned CW = $clog2(MAX_CORNERS + 1);

	logic [CW-1:0]    cc_q;
	logic [1:0]       pend_q;
	logic             err_q;
	logic [KEY_W-1:0] h0_pos_q, h0_tex_q, h0_norm_q;
	logic [KEY_W-1:0] h1_pos_q, h1_tex_q, h1_norm_q;
	logic [KEY_W-1:0] cur_pos_q, cur_tex_q, cur_norm_q;
	logic             acc;

	assign in_ready = (pend_q == 2'd0);
	assign acc      = in_valid && in_ready;
	assign push     = (pend_q != 2'd0) && !full;

	always_comb begin
		push_job.short_face = err_q;
		push_job.last       = (pend_q == 2'd1);
		case (pend_q)
			2'd3: begin
				push_job.pos  = h0_pos_q;
				push_job.tex  = h0_tex_q;
				push_job.norm = h0_norm_q;
			end
			2'd2: begin
				push_job.pos  = h1_pos_q;
				push_job.tex  = h1_tex_q;
				push_job.norm = h1_norm_q;
			end
			default: begin
				push_job.pos  = cur_pos_q;
				push_job.tex  = cur_tex_q;
				push_job.norm = cur_norm_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			pend_q <= '0;
			err_q  <= 1'b0;
		end else if (acc) begin
			if (cc_q >= CW'(MAX_CORNERS)) begin
				if (last_corner) cc_q <= '0;
			end else if (cc_q < CW'(2)) begin
				// still collecting the fan anchor; a face ending here is short
				if (last_corner) begin
					cc_q   <= '0;
					pend_q <= 2'd1;
					err_q  <= 1'b1;
				end else begin
					cc_q <= cc_q + 1'b1;
				end
			end else begin
				cc_q   <= last_corner ? '0 : cc_q + 1'b1;
				pend_q <= 2'd3;
				err_q  <= 1'b0;
			end
		end else if (push) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cc_q == CW'(0)) begin
			h0_pos_q  <= pos_index;
			h0_tex_q  <= tex_index;
			h0_norm_q <= norm_index;
		end
		if (acc && cc_q == CW'(1)) begin
			h1_pos_q  <= pos_index;
			h1_tex_q  <= tex_index;
			h1_norm_q <= norm_index;
		end
		if (acc) begin
			cur_pos_q  <= pos_index;
			cur_tex_q  <= tex_index;
			cur_norm_q <= norm_index;
		end
		// current corner becomes the previous corner once its request is out
		if (push && pend_q == 2'd1 && !err_q) begin
			h1_pos_q  <= cur_pos_q;
			h1_tex_q  <= cur_tex_q;
			h1_norm_q <= cur_norm_q;
		end
	end

endmodule

FILE: sv/fvd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_back
// Lookup engine: FNV-1a hash, bucket walk, insert on miss, result register.
// ----------------------------------------------------------------------------
module fvd_back
	import fvd_pkg::*;
#(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned BUCKET_WAYS  = 4,
	parameter int unsigned MAX_VERTICES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  job_t              q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MESH_W-1:0] mesh_index,
	output logic              is_new,
	output logic [1:0]        status,
	output logic [VTOT_W-1:0] vertex_total,
	output logic [ITOT_W-1:0] index_total,
	output logic              last_of_run
);

	localparam int unsigned BW  = $clog2(HASH_BUCKETS);
	localparam int unsigned AW  = $clog2(HASH_BUCKETS * BUCKET_WAYS);
	localparam int unsigned FW  = $clog2(BUCKET_WAYS + 1);
	localparam int unsigned VW  = $clog2(MAX_VERTICES + 1);
	localparam int unsigned EW  = 3 * KEY_W + MESH_W;
	localparam bit          POW2 = ((HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0);

	back_state_t state_q, state_d;

	logic [BW-1:0]     clr_q;
	logic [1:0]        step_q;
	logic [2:0]        bit_q;
	logic [31:0]       h_q;
	logic [BW-1:0]     rem_q;
	logic [BW-1:0]     bucket_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     way_q;
	logic [VW-1:0]     vc_q;
	logic [ITOT_W-1:0] ic_q;
	job_t              job_q;

	logic [31:0]       prod;
	logic [BW+3:0]     rem_sh;
	logic [BW+3:0]     rem_nx;
	logic [AW-1:0]     base;
	logic              fill_we;
	logic [BW-1:0]     fill_waddr;
	logic [FW-1:0]     fill_wdata;
	logic [FW-1:0]     fill_rdata;
	logic              ent_we;
	logic [AW-1:0]     ent_waddr;
	logic [AW-1:0]     ent_raddr;
	logic [EW-1:0]     ent_wdata;
	logic [EW-1:0]     ent_rdata;
	logic              hit;
	logic              way_end;
	logic              no_room;
	logic [24:0]       vc_ext;
	logic [24:0]       vc_inc;
	logic [ITOT_W-1:0] ic_inc;

	assign prod    = h_q * FNV_PRIME;
	assign rem_sh  = {rem_q, h_q[31:28]};
	assign base    = AW'(bucket_q) * AW'(BUCKET_WAYS);
	assign hit     = (ent_rdata[EW-1 -: 3*KEY_W] == {job_q.pos, job_q.tex, job_q.norm});
	assign way_end = ((way_q + 1'b1) == fill_q);
	assign no_room = (fill_q >= FW'(BUCKET_WAYS)) || (vc_q >= VW'(MAX_VERTICES));
	assign vc_ext  = 25'(vc_q);
	assign vc_inc  = vc_ext + 25'd1;
	assign ic_inc  = (ic_q == ITOT_MAX) ? ic_q : ic_q + 1'b1;

	// one nibble of remainder: compare against all fifteen multiples at once
	always_comb begin
		rem_nx = rem_sh;
		for (int k = 1; k < 16; k++) begin
			if (rem_sh >= (BW+4)'(k * HASH_BUCKETS))
				rem_nx = rem_sh - (BW+4)'(k * HASH_BUCKETS);
		end
	end

	fvd_ram #(.WIDTH(FW), .DEPTH(HASH_BUCKETS)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (bucket_q),
		.rdata (fill_rdata)
	);

	fvd_ram #(.WIDTH(EW), .DEPTH(HASH_BUCKETS * BUCKET_WAYS)) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR:   if (clr_q == BW'(HASH_BUCKETS - 1)) state_d = B_IDLE;
			B_IDLE: begin
				if (q_nonempty) state_d = q_job.short_face ? B_OUT : B_HASH;
			end
			B_HASH:    if (step_q == 2'd2) state_d = B_MOD;
			B_MOD:     if (POW2 || bit_q == 3'd7) state_d = B_FILL_RD;
			B_FILL_RD: state_d = B_FILL;
			B_FILL:    state_d = (fill_rdata == '0) ? B_DECIDE : B_WAY_RD;
			B_WAY_RD:  state_d = B_WAY_CMP;
			B_WAY_CMP: begin
				if (hit)          state_d = B_OUT;
				else if (way_end) state_d = B_DECIDE;
				else              state_d = B_WAY_RD;
			end
			B_DECIDE:  state_d = B_OUT;
			B_OUT:     if (out_ready) state_d = B_IDLE;
			default:   state_d = B_IDLE;
		endcase
	end

	// memory and queue controls
	always_comb begin
		q_pop      = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = fill_q + 1'b1;
		ent_we     = 1'b0;
		ent_waddr  = base + AW'(fill_q);
		ent_wdata  = {job_q.pos, job_q.tex, job_q.norm, vc_ext[MESH_W-1:0]};
		ent_raddr  = base + AW'(way_q);
		case (state_q)
			B_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			B_IDLE:   q_pop = q_nonempty;
			B_DECIDE: begin
				fill_we = !no_room;
				ent_we  = !no_room;
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			vc_q    <= '0;
			ic_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == B_WAY_CMP && hit) ic_q <= ic_inc;
			if (state_q == B_DECIDE && !no_room) begin
				ic_q <= ic_inc;
				vc_q <= vc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q  <= q_job;
				h_q    <= FNV_BASIS ^ 32'(q_job.pos);
				step_q <= 2'd0;
				// short face error result
				mesh_index   <= '0;
				is_new       <= 1'b0;
				status       <= ST_SHORT;
				vertex_total <= vc_ext[VTOT_W-1:0];
				index_total  <= ic_q;
				last_of_run  <= q_job.last;
			end
			B_HASH: begin
				step_q <= step_q + 1'b1;
				case (step_q)
					2'd0:    h_q <= prod ^ 32'(job_q.tex);
					2'd1:    h_q <= prod ^ 32'(job_q.norm);
					default: h_q <= prod;
				endcase
				rem_q <= '0;
				bit_q <= '0;
			end
			B_MOD: begin
				// bucket count not a power of two: remainder a nibble a cycle
				if (POW2) begin
					bucket_q <= h_q[BW-1:0];
				end else begin
					rem_q    <= rem_nx[BW-1:0];
					h_q      <= {h_q[27:0], 4'b0};
					bit_q    <= bit_q + 1'b1;
					bucket_q <= rem_nx[BW-1:0];
				end
			end
			B_FILL: begin
				fill_q <= fill_rdata;
				way_q  <= '0;
			end
			B_WAY_CMP: begin
				way_q <= way_q + 1'b1;
				if (hit) begin
					mesh_index   <= ent_rdata[MESH_W-1:0];
					is_new       <= 1'b0;
					status       <= ST_OK;
					vertex_total <= vc_ext[VTOT_W-1:0];
					index_total  <= ic_inc;
				end
			end
			B_DECIDE: begin
				if (no_room) begin
					mesh_index   <= '0;
					is_new       <= 1'b0;
					status       <= ST_FULL;
					vertex_total <= vc_ext[VTOT_W-1:0];
					index_total  <= ic_q;
				end else begin
					mesh_index   <= vc_ext[MESH_W-1:0];
					is_new       <= 1'b1;
					status       <= ST_OK;
					vertex_total <= vc_inc[VTOT_W-1:0];
					index_total  <= ic_inc;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/fan_triangulate_vertex_dedup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_triangulate_vertex_dedup_core
// Fan-triangulates faces and maps each triangle corner to a deduplicated
// vertex index through an FNV-1a hashed, set-associative key table.
// ----------------------------------------------------------------------------
// Sequence: per lookup the engine pops a request, hashes it, reduces the hash
//   to a bucket, reads the bucket fill count, walks the ways (read, compare),
//   decides on a miss and holds the result until out_ready.
// Throughput: one lookup at a time in the engine; a triangle is three lookups.
// Reset: asynchronous; afterwards a clearing pass writes the bucket fill RAM
//   before the first request is served.
// ----------------------------------------------------------------------------
module fan_triangulate_vertex_dedup_core
	import fvd_pkg::*;
#(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned BUCKET_WAYS  = 4,
	parameter int unsigned MAX_CORNERS  = 32,
	parameter int unsigned MAX_VERTICES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KEY_W-1:0]  pos_index,
	input  logic [KEY_W-1:0]  tex_index,
	input  logic [KEY_W-1:0]  norm_index,
	input  logic              last_corner,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MESH_W-1:0] mesh_index,
	output logic              is_new,
	output logic [1:0]        status,
	output logic [VTOT_W-1:0] vertex_total,
	output logic [ITOT_W-1:0] index_total,
	output logic              last_of_run
);

	logic push, full, pop, nonempty;
	job_t push_job, pop_job;

	fvd_front #(.MAX_CORNERS(MAX_CORNERS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_index   (pos_index),
		.tex_index   (tex_index),
		.norm_index  (norm_index),
		.last_corner (last_corner),
		.push        (push),
		.push_job    (push_job),
		.full        (full)
	);

	fvd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.nonempty (nonempty)
	);

	fvd_back #(
		.HASH_BUCKETS (HASH_BUCKETS),
		.BUCKET_WAYS  (BUCKET_WAYS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (nonempty),
		.q_job        (pop_job),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mesh_index   (mesh_index),
		.is_new       (is_new),
		.status       (status),
		.vertex_total (vertex_total),
		.index_total  (index_total),
		.last_of_run  (last_of_run)
	);

endmodule
